/* hdl/hng_pkg.sv */
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types and constants of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int CNT_W      = 11;
	localparam int MAX_ROWS   = 4096;
	localparam int ROW_W      = 13;
	localparam int STEP_W     = 12;
	localparam int H_W        = 16;
	localparam int D_W        = H_W + 1;
	localparam int MAG_W      = 29;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int SQ_W       = 60;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int Q_W        = 15;
	localparam int SUM_W      = 18;
	localparam int ONE_Q14    = 16384;
	localparam int FIFO_DEPTH = 4;
	localparam int CFG_W      = 13;

	localparam logic [1:0] CFG_NUM_COLS = 2'd0;
	localparam logic [1:0] CFG_NUM_ROWS = 2'd1;
	localparam logic [1:0] CFG_STEP_X   = 2'd2;
	localparam logic [1:0] CFG_STEP_Y   = 2'd3;

	typedef struct packed {
		logic                  func;
		logic signed [H_W-1:0] height;
	} hng_req_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               frame_last;
	} hng_res_t;

	// saturated frame geometry
	typedef struct packed {
		logic [CNT_W-1:0]  cols;
		logic [ROW_W-1:0]  rows;
		logic [STEP_W-1:0] dx;
		logic [STEP_W-1:0] dy;
	} hng_geom_t;

	// one grid point with its neighborhood, front to back
	typedef struct packed {
		logic [H_W-1:0] h;
		logic [H_W-1:0] e;
		logic [H_W-1:0] s;
		logic [H_W-1:0] n;
		logic [H_W-1:0] w;
		logic           he;
		logic           hs;
		logic           hn;
		logic           hw;
		logic           last;
	} hng_job_t;

endpackage

/* hdl/hng_front.sv */
// ----------------------------------------------------------------------------
// hng_front
// Raster position tracking, line buffers and neighborhood gathering.
// ----------------------------------------------------------------------------
module hng_front import hng_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hng_geom_t geom,
	input  logic      req_valid,
	output logic      req_stall,
	input  hng_req_t  req_data,
	output logic      push,
	output hng_job_t  push_job,
	input  logic      full
);

	typedef enum logic {F_IDLE, F_READ} fstate_t;

	fstate_t          state_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [H_W-1:0]   east_q;
	logic [H_W-1:0]   samp_q;
	logic [COL_W-1:0] pc_q;
	logic             emit_q, last_q, wr_q, he_q, hs_q, hn_q, hw_q;

	logic [H_W-1:0] middle_mem [MAX_COLS];
	logic [H_W-1:0] upper_mem [MAX_COLS];
	logic [H_W-1:0] mid_c_q, mid_e_q, up_c_q, up_w_q;

	logic [COL_W-1:0] c, pc, wcol, cols_m1;
	logic [ROW_W-1:0] r, pr;
	logic [ROW_W:0]   rows_p1;
	logic             emit, last, accept, leave;

	assign req_stall = (state_q != F_IDLE);
	assign accept    = req_valid && !req_stall;
	assign leave     = (state_q == F_READ) && !(emit_q && full);
	assign push      = (state_q == F_READ) && emit_q && !full;

	always_comb begin
		cols_m1 = COL_W'(geom.cols - CNT_W'(1));
		rows_p1 = {1'b0, geom.rows} + (ROW_W+1)'(1);
		// out-of-frame position restarts the frame
		if ({1'b0, col_q} >= geom.cols || {1'b0, row_q} > rows_p1 ||
				({1'b0, row_q} == rows_p1 && col_q != '0)) begin
			c = '0;
			r = '0;
		end else begin
			c = col_q;
			r = row_q;
		end
		emit = (r >= ROW_W'(2)) || (r == ROW_W'(1) && c != '0);
		last = ({1'b0, r} == rows_p1) && (c == '0);
		if (c != '0) begin
			pr = r - ROW_W'(1);
			pc = c - COL_W'(1);
		end else begin
			pr = (r >= ROW_W'(2)) ? r - ROW_W'(2) : '0;
			pc = cols_m1;
		end
		wcol = (pc != '0) ? pc - COL_W'(1) : cols_m1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_c_q <= middle_mem[pc];
			mid_e_q <= middle_mem[c];
			up_c_q  <= upper_mem[pc];
			up_w_q  <= upper_mem[wcol];
		end
		// previous sample lands in its column
		if (leave && wr_q) begin
			upper_mem[pc_q]  <= mid_c_q;
			middle_mem[pc_q] <= east_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			east_q  <= '0;
			samp_q  <= '0;
			pc_q    <= '0;
			emit_q  <= 1'b0;
			last_q  <= 1'b0;
			wr_q    <= 1'b0;
			he_q    <= 1'b0;
			hs_q    <= 1'b0;
			hn_q    <= 1'b0;
			hw_q    <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						samp_q <= req_data.func ? '0 : req_data.height;
						pc_q   <= pc;
						emit_q <= emit;
						last_q <= last;
						wr_q   <= (r != '0) || (c != '0);
						he_q   <= ({1'b0, pc} + CNT_W'(1)) < geom.cols;
						hs_q   <= ({1'b0, pr} + (ROW_W+1)'(1)) < {1'b0, geom.rows};
						hn_q   <= (pr != '0);
						hw_q   <= (pc != '0);
						if (last) begin
							col_q <= '0;
							row_q <= '0;
						end else if (({1'b0, c} + CNT_W'(1)) >= geom.cols) begin
							col_q <= '0;
							row_q <= r + ROW_W'(1);
						end else begin
							col_q <= c + COL_W'(1);
							row_q <= r;
						end
						state_q <= F_READ;
					end
				end
				F_READ: begin
					if (leave) begin
						east_q  <= samp_q;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_comb begin
		push_job.h    = mid_c_q;
		push_job.e    = mid_e_q;
		push_job.s    = east_q;
		push_job.n    = up_c_q;
		push_job.w    = up_w_q;
		push_job.he   = he_q;
		push_job.hs   = hs_q;
		push_job.hn   = hn_q;
		push_job.hw   = hw_q;
		push_job.last = last_q;
	end

endmodule

/* hdl/hng_fifo.sv */
// ----------------------------------------------------------------------------
// hng_fifo
// Short queue of gathered grid points between front and back.
// ----------------------------------------------------------------------------
module hng_fifo import hng_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hng_job_t push_job,
	output logic     full,
	input  logic     pop,
	output hng_job_t pop_job,
	output logic     empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	hng_job_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [CNT_FW-1:0]  cnt_q;

	assign full    = (cnt_q == CNT_FW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_FW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_FW'(1);
			end
		end
	end

endmodule

/* hdl/hng_back.sv */
// ----------------------------------------------------------------------------
// hng_back
// Quadrant cross products, shared multiplier, bit-serial sqrt and divider.
// ----------------------------------------------------------------------------
module hng_back import hng_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hng_geom_t geom,
	input  logic      empty,
	output logic      pop,
	input  hng_job_t  pop_job,
	output logic      res_valid,
	input  logic      res_stall,
	output hng_res_t  res_data
);

	typedef enum logic [2:0] {
		B_IDLE, B_QSEL, B_MUL, B_SQ, B_SQRT, B_DIV, B_ACC, B_OUT
	} bstate_t;

	bstate_t                  state_q;
	logic signed [D_W-1:0]    eh_q, sh_q, nh_q, wh_q;
	logic [3:0]               pres_q;
	logic                     last_q, fin_q;
	logic [2:0]               qd_q;
	logic [1:0]               k_q;
	logic [3:0]               i_q;
	logic [4:0]               it_q;
	logic                     vneg_q [3];
	logic [MAG_W-1:0]         vmag_q [3];
	logic [Q_W-1:0]           nq_q [3];
	logic [SQ_W-1:0]          sv_q, res_q, bit_q;
	logic [ROOT_W-1:0]        len_q;
	logic [ROOT_W:0]          rem_q;
	logic [Q_W-1:0]           quo_q;
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [PROD_W-1:0]        prod_q;

	logic [MAG_W-1:0]   mul_a, mul_b;
	logic               mul_neg;
	logic signed [D_W-1:0] d0, d1;
	logic               f0, f1;
	logic [SQ_W:0]      sq_t;
	logic               sq_ge;
	logic [SQ_W-1:0]    sq_res;
	logic [ROOT_W:0]    dv_cand, dv_rem;
	logic               dv_ge;
	hng_res_t           out_q;

	function automatic logic [D_W-1:0] mag_d(input logic signed [D_W-1:0] v);
		mag_d = v[D_W-1] ? D_W'(-v) : D_W'(v);
	endfunction

	function automatic logic signed [SUM_W-1:0] sgn_q(input logic neg,
			input logic [Q_W-1:0] q);
		logic signed [SUM_W-1:0] p;
		p = $signed({{(SUM_W-Q_W){1'b0}}, q});
		sgn_q = neg ? -p : p;
	endfunction

	assign pop       = (state_q == B_IDLE) && !empty;
	assign res_data  = out_q;

	// operand selection for the shared multiplier
	always_comb begin
		d0  = qd_q[1] ? wh_q : eh_q;
		f0  = !qd_q[1];
		f1  = !(qd_q == 3'd1 || qd_q == 3'd2);
		d1  = f1 ? sh_q : nh_q;
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		if (state_q == B_MUL) begin
			case (k_q)
				2'd0: begin
					mul_a   = MAG_W'(mag_d(d0));
					mul_b   = MAG_W'(geom.dy);
					mul_neg = d0[D_W-1] ^ f0;
				end
				2'd1: begin
					mul_a   = MAG_W'(mag_d(d1));
					mul_b   = MAG_W'(geom.dx);
					mul_neg = d1[D_W-1] ^ f1;
				end
				default: begin
					mul_a = MAG_W'(geom.dx);
					mul_b = MAG_W'(geom.dy);
				end
			endcase
		end else if (state_q == B_SQ) begin
			case (k_q)
				2'd0: begin mul_a = vmag_q[0]; mul_b = vmag_q[0]; end
				2'd1: begin mul_a = vmag_q[1]; mul_b = vmag_q[1]; end
				2'd2: begin mul_a = vmag_q[2]; mul_b = vmag_q[2]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// one root digit per cycle
	always_comb begin
		sq_t   = {1'b0, res_q} + {1'b0, bit_q};
		sq_ge  = {1'b0, sv_q} >= sq_t;
		sq_res = sq_ge ? (res_q >> 1) + bit_q : (res_q >> 1);
	end

	// one quotient bit per cycle
	always_comb begin
		case (k_q)
			2'd0: dv_cand = {2'b00, vmag_q[0]};
			2'd1: dv_cand = {2'b00, vmag_q[1]};
			default: dv_cand = {2'b00, vmag_q[2]};
		endcase
		if (i_q != '0) begin
			dv_cand = {rem_q[ROOT_W-1:0], 1'b0};
		end
		dv_ge  = dv_cand >= {1'b0, len_q};
		dv_rem = dv_ge ? dv_cand - {1'b0, len_q} : dv_cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			res_valid <= 1'b0;
			out_q     <= '0;
			eh_q      <= '0;
			sh_q      <= '0;
			nh_q      <= '0;
			wh_q      <= '0;
			pres_q    <= '0;
			last_q    <= 1'b0;
			fin_q     <= 1'b0;
			qd_q      <= '0;
			k_q       <= '0;
			i_q       <= '0;
			it_q      <= '0;
			sv_q      <= '0;
			res_q     <= '0;
			bit_q     <= '0;
			len_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			for (int j = 0; j < 3; j++) begin
				vneg_q[j] <= 1'b0;
				vmag_q[j] <= '0;
				nq_q[j]   <= '0;
				sum_q[j]  <= '0;
			end
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						eh_q   <= $signed({pop_job.e[H_W-1], pop_job.e} -
							{pop_job.h[H_W-1], pop_job.h});
						sh_q   <= $signed({pop_job.s[H_W-1], pop_job.s} -
							{pop_job.h[H_W-1], pop_job.h});
						nh_q   <= $signed({pop_job.n[H_W-1], pop_job.n} -
							{pop_job.h[H_W-1], pop_job.h});
						wh_q   <= $signed({pop_job.w[H_W-1], pop_job.w} -
							{pop_job.h[H_W-1], pop_job.h});
						pres_q <= {pop_job.hw && pop_job.hs, pop_job.hn && pop_job.hw,
							pop_job.he && pop_job.hn, pop_job.hs && pop_job.he};
						last_q <= pop_job.last;
						fin_q  <= 1'b0;
						qd_q   <= '0;
						for (int j = 0; j < 3; j++) begin
							sum_q[j] <= '0;
						end
						state_q <= B_QSEL;
					end
				end
				B_QSEL: begin
					if (qd_q == 3'd4) begin
						// final pass over the summed normals
						for (int j = 0; j < 3; j++) begin
							vneg_q[j] <= sum_q[j][SUM_W-1];
							vmag_q[j] <= MAG_W'(sum_q[j][SUM_W-1] ?
								-sum_q[j] : sum_q[j]);
						end
						fin_q   <= 1'b1;
						k_q     <= '0;
						state_q <= B_SQ;
					end else if (pres_q[qd_q[1:0]]) begin
						k_q     <= '0;
						state_q <= B_MUL;
					end else begin
						// edge quadrant contributes straight up
						sum_q[2] <= sum_q[2] + SUM_W'(ONE_Q14);
						qd_q     <= qd_q + 3'd1;
					end
				end
				B_MUL: begin
					case (k_q)
						2'd0: vneg_q[0] <= mul_neg;
						2'd1: begin
							vneg_q[1] <= mul_neg;
							vmag_q[0] <= prod_q[MAG_W-1:0];
						end
						2'd2: begin
							vneg_q[2] <= mul_neg;
							vmag_q[1] <= prod_q[MAG_W-1:0];
						end
						default: vmag_q[2] <= prod_q[MAG_W-1:0];
					endcase
					if (k_q == 2'd3) begin
						k_q     <= '0;
						state_q <= B_SQ;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				B_SQ: begin
					if (k_q == '0) begin
						sv_q <= '0;
					end else begin
						sv_q <= sv_q + SQ_W'(prod_q);
					end
					if (k_q == 2'd3) begin
						res_q   <= '0;
						bit_q   <= SQ_W'(1) << (SQ_W - 2);
						it_q    <= '0;
						state_q <= B_SQRT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				B_SQRT: begin
					if (sq_ge) begin
						sv_q <= sv_q - sq_t[SQ_W-1:0];
					end
					res_q <= sq_res;
					bit_q <= bit_q >> 2;
					it_q  <= it_q + 5'd1;
					if (it_q == 5'(ROOT_W - 1)) begin
						len_q <= sq_res[ROOT_W-1:0];
						k_q   <= '0;
						i_q   <= '0;
						if (sq_res == '0) begin
							state_q <= B_ACC;
						end else begin
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					rem_q <= dv_rem;
					quo_q <= {quo_q[Q_W-2:0], dv_ge};
					if (i_q == 4'(Q_W - 1)) begin
						case (k_q)
							2'd0: nq_q[0] <= {quo_q[Q_W-2:0], dv_ge};
							2'd1: nq_q[1] <= {quo_q[Q_W-2:0], dv_ge};
							default: nq_q[2] <= {quo_q[Q_W-2:0], dv_ge};
						endcase
						i_q <= '0;
						if (k_q == 2'd2) begin
							state_q <= B_ACC;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						i_q <= i_q + 4'd1;
					end
				end
				B_ACC: begin
					if (!fin_q) begin
						for (int j = 0; j < 3; j++) begin
							sum_q[j] <= sum_q[j] + sgn_q(vneg_q[j], nq_q[j]);
						end
						qd_q    <= qd_q + 3'd1;
						state_q <= B_QSEL;
					end else begin
						if (len_q == '0) begin
							out_q.normal_x <= '0;
							out_q.normal_y <= '0;
							out_q.normal_z <= 16'(ONE_Q14);
						end else begin
							out_q.normal_x <= 16'(sgn_q(vneg_q[0], nq_q[0]));
							out_q.normal_y <= 16'(sgn_q(vneg_q[1], nq_q[1]));
							out_q.normal_z <= 16'(sgn_q(vneg_q[2], nq_q[2]));
						end
						out_q.frame_last <= last_q;
						res_valid        <= 1'b1;
						state_q          <= B_OUT;
					end
				end
				B_OUT: begin
					if (!res_stall) begin
						res_valid <= 1'b0;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (len_q != '0))
		else $error("divide started with zero length");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ACC) |-> (nq_q[0] <= Q_W'(ONE_Q14) &&
			nq_q[1] <= Q_W'(ONE_Q14) && nq_q[2] <= Q_W'(ONE_Q14)))
		else $error("normalized component above one");

	a_res_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == B_ACC && fin_q))
		else $error("result raised outside final accumulate");

endmodule

/* hdl/heightmap_normal_generator_unit.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_generator_unit
// Front: every request, emitting or not, is taken in F_IDLE and holds F_READ
// until its point, if any, is pushed. The back runs an emitted point through
// up to four quadrant passes and a final pass (B_MUL, B_SQ, B_SQRT, B_DIV,
// B_ACC) and takes no new point until its result leaves B_OUT, with a shared
// bit-serial square root and divider. A 4-entry queue decouples both.
// Reset: control cleared, config set to defaults at once; line buffers
// undefined, no sweep.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit import hng_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  hng_req_t         req_data,
	output logic             res_valid,
	input  logic             res_stall,
	output hng_res_t         res_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CNT_W-1:0]  num_cols_q;
	logic [ROW_W-1:0]  num_rows_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	hng_geom_t         geom;
	logic              push, full, pop, empty;
	hng_job_t          push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= 11'd1024;
			num_rows_q <= 13'd1024;
			step_x_q   <= 12'd1;
			step_y_q   <= 12'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_COLS: num_cols_q <= cfg_data[CNT_W-1:0];
				CFG_NUM_ROWS: num_rows_q <= cfg_data[ROW_W-1:0];
				CFG_STEP_X:   step_x_q   <= cfg_data[STEP_W-1:0];
				CFG_STEP_Y:   step_y_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers into their usable range
	always_comb begin
		if (num_cols_q < CNT_W'(2)) begin
			geom.cols = CNT_W'(2);
		end else if (num_cols_q > CNT_W'(MAX_COLS)) begin
			geom.cols = CNT_W'(MAX_COLS);
		end else begin
			geom.cols = num_cols_q;
		end
		if (num_rows_q < ROW_W'(2)) begin
			geom.rows = ROW_W'(2);
		end else if (num_rows_q > ROW_W'(MAX_ROWS)) begin
			geom.rows = ROW_W'(MAX_ROWS);
		end else begin
			geom.rows = num_rows_q;
		end
		geom.dx = (step_x_q == '0) ? STEP_W'(1) : step_x_q;
		geom.dy = (step_y_q == '0) ? STEP_W'(1) : step_y_q;
	end

	hng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	hng_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	hng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.empty     (empty),
		.pop       (pop),
		.pop_job   (pop_job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
